// File: rtl/fault_formation_heightmap_defines.svh
// assertion macros for the fault formation heightmap
// used by the rtl files that carry concurrent checks
`ifndef FAULT_FORMATION_HEIGHTMAP_DEFINES_SVH
`define FAULT_FORMATION_HEIGHTMAP_DEFINES_SVH
`ifndef SYNTHESIS
`define FFH_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ffh check failed");
`define FFH_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ffh reset check failed");
`else
`define FFH_ASSERT(label, prop)
`define FFH_ASSERT_RST(label, prop)
`endif
`endif

// File: rtl/ffh_pkg.sv
// shared types and constants for the fault formation heightmap
// no dependencies
package ffh_pkg;
  localparam int GridBits = 8;
  localparam int AddrBits = 2 * GridBits;
  localparam int KOne     = 65536;

  typedef enum logic [1:0] {
    CMD_FAULT  = 2'd0,
    CMD_SMOOTH = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_MIN   = 2'd0,
    REG_MAX   = 2'd1,
    REG_COUNT = 2'd2,
    REG_COEF  = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_FRD, S_FWR, S_SRD, S_SWR, S_RRD, S_RWT, S_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  point_a_x;
    logic [7:0]  point_a_z;
    logic [7:0]  point_b_x;
    logic [7:0]  point_b_z;
    logic [15:0] fault_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         done_cmd;
    logic signed [31:0] cell_height;
  } out_item_t;

  typedef struct packed {
    logic                we;
    logic [AddrBits-1:0] addr;
    logic [31:0]         wdata;
  } map_req_t;
endpackage

// File: rtl/ffh_div.sv
// fault height unit: one multiply, then restoring division one bit a cycle
// depends on ffh_pkg
module ffh_div import ffh_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] max_h,
  input  logic signed [31:0] min_h,
  input  logic [15:0]        idx,
  input  logic [15:0]        count,
  output logic               done,
  output logic signed [31:0] height
);
  logic               busy;
  logic               mul_phase;
  logic [5:0]         step;
  logic signed [31:0] mx;
  logic signed [32:0] dl;
  logic [15:0]        idx_r;
  logic [15:0]        cnt;
  logic               neg;
  logic [48:0]        num;
  logic [15:0]        rem;
  logic signed [49:0] prod;
  logic [16:0]        trial;
  logic [48:0]        sq;

  assign prod  = $signed({1'b0, idx_r}) * dl;
  assign trial = {rem, num[48]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      mul_phase <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        mul_phase <= 1'b1;
      end else if (busy && mul_phase) begin
        mul_phase <= 1'b0;
      end else if (busy && step == 6'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mx    <= max_h;
      dl    <= 33'(max_h) - 33'(min_h);
      idx_r <= idx;
      cnt   <= count;
    end else if (busy && mul_phase) begin
      neg  <= prod[49];
      num  <= prod[49] ? 49'(-prod) : prod[48:0];
      rem  <= '0;
      step <= 6'd49;
    end else if (busy) begin
      step <= step - 6'd1;
      if (trial >= {1'b0, cnt}) begin
        rem <= 16'(trial - {1'b0, cnt});
        num <= {num[47:0], 1'b1};
      end else begin
        rem <= trial[15:0];
        num <= {num[47:0], 1'b0};
      end
    end
  end

  // quotient truncates toward zero, sign restored here
  assign sq     = neg ? 49'(-num) : num;
  assign height = (cnt == 16'd0) ? mx : mx - $signed(sq[31:0]);
endmodule

// File: rtl/ffh_map.sv
// height map storage, one port shared by read and write, registered read
// depends on ffh_pkg
module ffh_map import ffh_pkg::*; (
  input  logic        clk,
  input  map_req_t    req,
  output logic [31:0] rd_data
);
  logic [31:0] mem [2**AddrBits];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rd_data <= mem[req.addr];
  end
endmodule

// File: rtl/fault_formation_heightmap.sv
// top level: command sequencer, fault and smoothing datapath, config registers
// depends on ffh_pkg, ffh_div, ffh_map and the assertion header
`include "fault_formation_heightmap_defines.svh"
// One request at a time; in_stall stays high until the result has been taken.
// After reset the map is cleared one cell a cycle, with in_stall high. Fault
// and smooth visit each cell as a read then a write on the single map port:
// fault divides the fault height one quotient bit a cycle, then sweeps the
// map; smooth makes four passes, each cell blended in turn; read fetches one
// cell.
module fault_formation_heightmap import ffh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  state_e              state, state_next;
  logic [AddrBits-1:0] addr;
  logic [1:0]          pass;
  logic [7:0]          line;
  logic [7:0]          cpos;
  logic signed [31:0]  rv;
  in_item_t            req_r;
  logic signed [31:0]  min_h, max_h;
  logic [15:0]         fcount;
  logic [16:0]         coef;
  logic                div_start, div_done;
  logic signed [31:0]  fheight;
  map_req_t            mreq;
  logic [31:0]         rd_data;
  logic                accept;

  logic [7:0]          pos;
  logic [AddrBits-1:0] saddr;
  logic signed [8:0]   xr, zr, dx, dz;
  logic signed [17:0]  p1, p2;
  logic signed [18:0]  cp;
  logic [16:0]         k;
  logic signed [32:0]  diff;
  logic signed [50:0]  kp;
  logic signed [31:0]  blend;

  assign accept = in_valid && !in_stall;

  ffh_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .max_h(max_h), .min_h(min_h),
    .idx(in_data.fault_index), .count(fcount), .done(div_done), .height(fheight)
  );

  ffh_map u_map (.clk(clk), .req(mreq), .rd_data(rd_data));

  // smoothing walk: reversed passes flip the position along the line
  assign pos   = cpos ^ {8{pass[0]}};
  assign saddr = pass[1] ? {pos, line} : {line, pos};

  // cross product of the cell against the fault line
  assign xr = $signed({1'b0, addr[7:0]}) - $signed({1'b0, req_r.point_a_x});
  assign zr = $signed({1'b0, addr[15:8]}) - $signed({1'b0, req_r.point_a_z});
  assign dx = $signed({1'b0, req_r.point_b_x}) - $signed({1'b0, req_r.point_a_x});
  assign dz = $signed({1'b0, req_r.point_b_z}) - $signed({1'b0, req_r.point_a_z});
  assign p1 = xr * dz;
  assign p2 = dx * zr;
  assign cp = 19'(p1) - 19'(p2);

  // k*prev + (1-k)*cur = cur + k*(prev-cur), floored by the arithmetic shift
  assign k     = (coef > 17'(KOne)) ? 17'(KOne) : coef;
  assign diff  = 33'(rv) - 33'($signed(rd_data));
  assign kp    = $signed({1'b0, k}) * diff;
  assign blend = $signed(rd_data) + $signed(kp[47:16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_h  <= '0;
      max_h  <= 32'sd65536;
      fcount <= 16'd1;
      coef   <= 17'd32768;
    end else if (cfg_we) begin
      case (reg_e'(cfg_index))
        REG_MIN:   min_h  <= cfg_data;
        REG_MAX:   max_h  <= cfg_data;
        REG_COUNT: fcount <= cfg_data[15:0];
        REG_COEF:  coef   <= cfg_data[16:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (addr == '1) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          case (cmd_e'(in_data.cmd))
            CMD_FAULT:  state_next = S_DIV;
            CMD_SMOOTH: state_next = S_SRD;
            CMD_READ:   state_next = S_RRD;
            default:    state_next = S_OUT;
          endcase
        end
      end
      S_DIV: if (div_done) state_next = S_FRD;
      S_FRD: state_next = S_FWR;
      S_FWR: state_next = (addr == '1) ? S_OUT : S_FRD;
      S_SRD: state_next = S_SWR;
      S_SWR: begin
        if (cpos == 8'hFF && line == 8'hFF && pass == 2'd3) state_next = S_OUT;
        else state_next = S_SRD;
      end
      S_RRD: state_next = S_RWT;
      S_RWT: state_next = S_OUT;
      S_OUT: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = (state != S_IDLE);
    out_valid  = (state == S_OUT);
    div_start  = accept && (cmd_e'(in_data.cmd) == CMD_FAULT);
    mreq.we    = 1'b0;
    mreq.addr  = addr;
    mreq.wdata = '0;
    case (state)
      S_CLEAR: mreq.we = 1'b1;
      S_FWR: begin
        mreq.we    = (cp > 19'sd0);
        mreq.wdata = rd_data + fheight;
      end
      S_SRD: mreq.addr = saddr;
      S_SWR: begin
        mreq.addr  = saddr;
        mreq.we    = (cpos != 8'd0);
        mreq.wdata = blend;
      end
      S_RRD: mreq.addr = {req_r.point_a_z, req_r.point_a_x};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_CLEAR: addr <= addr + 1'b1;
      S_IDLE: begin
        if (accept) begin
          req_r                <= in_data;
          addr                 <= '0;
          pass                 <= '0;
          line                 <= '0;
          cpos                 <= '0;
          out_data.done_cmd    <= in_data.cmd;
          out_data.cell_height <= '0;
        end
      end
      S_FWR: addr <= addr + 1'b1;
      S_SWR: begin
        // edge cell seeds the running value
        rv   <= (cpos == 8'd0) ? $signed(rd_data) : blend;
        cpos <= cpos + 8'd1;
        if (cpos == 8'hFF) begin
          line <= line + 8'd1;
          if (line == 8'hFF) pass <= pass + 2'd1;
        end
      end
      S_RWT: out_data.cell_height <= rd_data;
      default: ;
    endcase
    if (rst) begin
      addr <= '0;
      rv   <= '0;
    end
  end

  `FFH_ASSERT(a_accept_leaves_idle, accept |=> (state != S_IDLE))
  `FFH_ASSERT(a_smooth_seed_no_write, (state == S_SWR && cpos == 8'd0) |-> !mreq.we)
  `FFH_ASSERT(a_out_blocks_in, out_valid |-> in_stall)
  `FFH_ASSERT_RST(a_reset_clears, $past(rst) |-> (state == S_CLEAR && !out_valid))
endmodule
